// ===== src/srgb_to_cielab_unit_assert.svh =====
// assertion macros shared by the conversion pipeline
`ifndef SRGB_TO_CIELAB_UNIT_ASSERT_SVH
`define SRGB_TO_CIELAB_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define S2LAB_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("s2lab check failed");

`define S2LAB_ASSERT_IMPLY(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("s2lab check failed");

`else

`define S2LAB_ASSERT_ALWAYS(label, cond)

`define S2LAB_ASSERT_IMPLY(label, pre, post)

`endif

`endif

// ===== src/s2lab_pkg.sv =====
`default_nettype none

package s2lab_pkg;

    localparam int LANES     = 3;
    localparam int LIN_W     = 31;
    localparam int COEF_W    = 17;
    localparam int SUM_W     = 47;
    localparam int WHITE_W   = 18;
    localparam int F_W       = 26;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_WHITE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WHITE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WHITE_Z = 2'd2;

    localparam logic [WHITE_W-1:0] WHITE_X_RST = 18'd95047;
    localparam logic [WHITE_W-1:0] WHITE_Y_RST = 18'd100000;
    localparam logic [WHITE_W-1:0] WHITE_Z_RST = 18'd108883;

    typedef logic [LIN_W-1:0]   lin_t;
    typedef logic [COEF_W-1:0]  coef_t;
    typedef logic [SUM_W-1:0]   sum_t;
    typedef logic [WHITE_W-1:0] white_t;
    typedef logic [F_W-1:0]     cie_f_t;
    typedef lin_t lin_lut_t [256];

    // matrix rows in ten-thousandths, scaled by ten
    localparam coef_t MAT_COEF [LANES][LANES] = '{
        '{17'd41240, 17'd35760, 17'd18050},
        '{17'd21260, 17'd71520, 17'd7220},
        '{17'd1930,  17'd11920, 17'd95050}
    };

    function automatic lin_t lin_value(input longint unsigned c);
        longint unsigned t;
        longint unsigned s;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned q2;
        longint unsigned q4;
        longint unsigned p5;
        if (c * 64'd100000 <= 64'd1031475)
        begin
            return lin_t'((c * (64'd1 << 30) * 64'd100) / 64'd329460);
        end
        t  = ((64'd1000 * c + 64'd14025) * (64'd1 << 30)) / 64'd269025;
        s  = (t * t) >> 30;
        lo = 64'd0;
        hi = 64'd1 << 30;
        for (int i = 0; i < 32; i++)
        begin
            if (lo < hi)
            begin
                mid = (lo + hi + 64'd1) >> 1;
                q2  = (mid * mid) >> 30;
                q4  = (q2 * q2) >> 30;
                p5  = (q4 * mid) >> 30;
                if (p5 <= s)
                begin
                    lo = mid;
                end
                else
                begin
                    hi = mid - 64'd1;
                end
            end
        end
        return lin_t'((s * lo) >> 30);
    endfunction

    function automatic lin_lut_t build_lin_lut();
        lin_lut_t lut;
        for (int c = 0; c < 256; c++)
        begin
            lut[c] = lin_value(longint'(c));
        end
        return lut;
    endfunction

    // srgb transfer curve, q30
    localparam lin_lut_t LIN_LUT = build_lin_lut();

endpackage

`default_nettype wire

// ===== src/s2lab_matrix.sv =====
`default_nettype none

module s2lab_matrix
    import s2lab_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [7:0]             red,
    input  logic [7:0]             green,
    input  logic [7:0]             blue,
    output logic                   out_valid,
    input  logic                   out_stall,
    output sum_t [LANES-1:0]       sums
);

    localparam int STAGES = 3;
    localparam int PROD_W = LIN_W + COEF_W;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_in;
    logic [STAGES:0]   adv;

    lin_t [LANES-1:0] lin_next;
    lin_t [LANES-1:0] lin_reg;
    logic [LANES-1:0][LANES-1:0][PROD_W-1:0] prod_next;
    logic [LANES-1:0][LANES-1:0][PROD_W-1:0] prod_reg;
    sum_t [LANES-1:0] sum_next;
    sum_t [LANES-1:0] sum_reg;

    always_comb
    begin
        adv[STAGES] = !out_stall;
        for (int s = STAGES - 1; s >= 0; s--)
        begin
            adv[s] = !valid_reg[s] || adv[s+1];
        end
    end

    assign valid_in  = {valid_reg[STAGES-2:0], in_valid};
    assign in_stall  = !adv[0];
    assign out_valid = valid_reg[STAGES-1];
    assign sums      = sum_reg;

    always_comb
    begin
        lin_next[0] = LIN_LUT[red];
        lin_next[1] = LIN_LUT[green];
        lin_next[2] = LIN_LUT[blue];
        for (int r = 0; r < LANES; r++)
        begin
            for (int c = 0; c < LANES; c++)
            begin
                prod_next[r][c] = PROD_W'(lin_reg[c]) * PROD_W'(MAT_COEF[r][c]);
            end
            sum_next[r] = SUM_W'(prod_reg[r][0] + prod_reg[r][1] + prod_reg[r][2]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int s = 0; s < STAGES; s++)
            begin
                if (adv[s])
                begin
                    valid_reg[s] <= valid_in[s];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            lin_reg <= lin_next;
        end
        if (adv[1])
        begin
            prod_reg <= prod_next;
        end
        if (adv[2])
        begin
            sum_reg <= sum_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/s2lab_ratio.sv =====
`default_nettype none

`include "srgb_to_cielab_unit_assert.svh"

module s2lab_ratio
    import s2lab_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  sum_t [LANES-1:0]       sums,
    input  white_t [LANES-1:0]     white,
    output logic                   out_valid,
    input  logic                   out_stall,
    output sum_t [LANES-1:0]       ratio
);

    localparam int STEPS  = 4;
    localparam int QUO_W  = SUM_W + 1;
    localparam int STAGES = QUO_W / STEPS;

    typedef logic [QUO_W-1:0] quo_t;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_in;
    logic [STAGES:0]   adv;

    white_t [LANES-1:0] divisor;
    white_t [STAGES-1:0][LANES-1:0] rem_in;
    white_t [STAGES-1:0][LANES-1:0] rem_next;
    white_t [STAGES-1:0][LANES-1:0] rem_reg;
    quo_t   [STAGES-1:0][LANES-1:0] word_in;
    quo_t   [STAGES-1:0][LANES-1:0] word_next;
    quo_t   [STAGES-1:0][LANES-1:0] word_reg;
    logic   rem_ok;

    always_comb
    begin
        adv[STAGES] = !out_stall;
        for (int s = STAGES - 1; s >= 0; s--)
        begin
            adv[s] = !valid_reg[s] || adv[s+1];
        end
    end

    assign valid_in  = {valid_reg[STAGES-2:0], in_valid};
    assign in_stall  = !adv[0];
    assign out_valid = valid_reg[STAGES-1];

    // a zero white point divides as one
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            divisor[l] = (white[l] == '0) ? WHITE_W'(1) : white[l];
            ratio[l]   = word_reg[STAGES-1][l][SUM_W-1:0];
        end
    end

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            rem_in[0][l]  = '0;
            word_in[0][l] = {1'b0, sums[l]};
        end
        for (int s = 1; s < STAGES; s++)
        begin
            rem_in[s]  = rem_reg[s-1];
            word_in[s] = word_reg[s-1];
        end
    end

    // restoring division, quotient bits shift in as dividend bits shift out
    always_comb
    begin
        white_t             rem_v;
        quo_t               word_v;
        logic [WHITE_W:0]   trial_v;
        for (int s = 0; s < STAGES; s++)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                rem_v  = rem_in[s][l];
                word_v = word_in[s][l];
                for (int k = 0; k < STEPS; k++)
                begin
                    trial_v = {rem_v, word_v[QUO_W-1]};
                    word_v  = {word_v[QUO_W-2:0], 1'b0};
                    if (trial_v >= {1'b0, divisor[l]})
                    begin
                        rem_v     = WHITE_W'(trial_v - {1'b0, divisor[l]});
                        word_v[0] = 1'b1;
                    end
                    else
                    begin
                        rem_v = trial_v[WHITE_W-1:0];
                    end
                end
                rem_next[s][l]  = rem_v;
                word_next[s][l] = word_v;
            end
        end
    end

    always_comb
    begin
        rem_ok = 1'b1;
        for (int l = 0; l < LANES; l++)
        begin
            if (rem_reg[STAGES-1][l] >= divisor[l])
            begin
                rem_ok = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int s = 0; s < STAGES; s++)
            begin
                if (adv[s])
                begin
                    valid_reg[s] <= valid_in[s];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < STAGES; s++)
        begin
            if (adv[s])
            begin
                rem_reg[s]  <= rem_next[s];
                word_reg[s] <= word_next[s];
            end
        end
    end

    `S2LAB_ASSERT_IMPLY(a_rem_below_divisor, valid_reg[STAGES-1], rem_ok)

endmodule

`default_nettype wire

// ===== src/s2lab_cbrt.sv =====
`default_nettype none

`include "srgb_to_cielab_unit_assert.svh"

module s2lab_cbrt
    import s2lab_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  sum_t [LANES-1:0]       ratio,
    output logic                   out_valid,
    input  logic                   out_stall,
    output cie_f_t [LANES-1:0]     f
);

    localparam int ROOT_W  = F_W;
    localparam int STAGES  = ROOT_W;
    localparam int SQ_W    = 2 * ROOT_W;
    localparam int REM_W   = SUM_W + 30;
    localparam int DW      = 80;
    localparam int P_W     = 37;
    localparam int LINF_W  = 18;
    localparam int MUL_W   = 48;

    localparam logic [SUM_W-1:0]  F_THRESH   = 47'd9509057;
    localparam logic [LINF_W-1:0] F_OFFSET   = 18'd144631;
    localparam logic [12:0]       LIN_SLOPE  = 13'd7787;
    localparam logic [23:0]       RECIP_125  = 24'd8589935;

    typedef logic [ROOT_W-1:0] root_t;
    typedef logic [SQ_W-1:0]   sq_t;
    typedef logic [REM_W-1:0]  rem_t;
    typedef logic [LINF_W-1:0] linf_t;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_in;
    logic [STAGES:0]   adv;

    root_t [STAGES-1:0][LANES-1:0] y_in;
    root_t [STAGES-1:0][LANES-1:0] y_next;
    root_t [STAGES-1:0][LANES-1:0] y_reg;
    sq_t   [STAGES-1:0][LANES-1:0] y2_in;
    sq_t   [STAGES-1:0][LANES-1:0] y2_next;
    sq_t   [STAGES-1:0][LANES-1:0] y2_reg;
    rem_t  [STAGES-1:0][LANES-1:0] rem_in;
    rem_t  [STAGES-1:0][LANES-1:0] rem_next;
    rem_t  [STAGES-1:0][LANES-1:0] rem_reg;
    logic  [STAGES-1:0][LANES-1:0] sel_in;
    logic  [STAGES-1:0][LANES-1:0] sel_reg;
    logic  [LANES-1:0][P_W-1:0]    p_next;
    logic  [LANES-1:0][P_W-1:0]    p_reg;
    linf_t [STAGES-1:1][LANES-1:0] linf_in;
    linf_t [STAGES-1:1][LANES-1:0] linf_reg;
    logic  root_ok;

    always_comb
    begin
        adv[STAGES] = !out_stall;
        for (int s = STAGES - 1; s >= 0; s--)
        begin
            adv[s] = !valid_reg[s] || adv[s+1];
        end
    end

    assign valid_in  = {valid_reg[STAGES-2:0], in_valid};
    assign in_stall  = !adv[0];
    assign out_valid = valid_reg[STAGES-1];

    // linear segment near black, the division by 125 as a reciprocal product
    always_comb
    begin
        logic [MUL_W-1:0] mul_v;
        for (int l = 0; l < LANES; l++)
        begin
            p_next[l]     = P_W'(ratio[l][23:0]) * P_W'(LIN_SLOPE);
            mul_v         = MUL_W'(p_reg[l][P_W-1:13]) * MUL_W'(RECIP_125);
            linf_in[1][l] = LINF_W'(mul_v >> 30) + F_OFFSET;
        end
        for (int s = 2; s < STAGES; s++)
        begin
            linf_in[s] = linf_reg[s-1];
        end
    end

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            y_in[0][l]   = '0;
            y2_in[0][l]  = '0;
            rem_in[0][l] = {ratio[l], {30{1'b1}}};
            sel_in[0][l] = (ratio[l] > F_THRESH);
        end
        for (int s = 1; s < STAGES; s++)
        begin
            y_in[s]   = y_reg[s-1];
            y2_in[s]  = y2_reg[s-1];
            rem_in[s] = rem_reg[s-1];
            sel_in[s] = sel_reg[s-1];
        end
    end

    // one root bit a stage, the cube tracked as a remainder
    always_comb
    begin
        logic [DW-1:0] delta_v;
        int            b;
        for (int s = 0; s < STAGES; s++)
        begin
            b = ROOT_W - 1 - s;
            for (int l = 0; l < LANES; l++)
            begin
                delta_v = ((DW'(y2_in[s][l]) << 1) + DW'(y2_in[s][l])) << b;
                delta_v = delta_v + (((DW'(y_in[s][l]) << 1) + DW'(y_in[s][l])) << (2 * b))
                          + (DW'(1) << (3 * b));
                if (delta_v <= DW'(rem_in[s][l]))
                begin
                    rem_next[s][l] = REM_W'(DW'(rem_in[s][l]) - delta_v);
                    y2_next[s][l]  = SQ_W'(DW'(y2_in[s][l]) + (DW'(y_in[s][l]) << (b + 1))
                                     + (DW'(1) << (2 * b)));
                    y_next[s][l]   = y_in[s][l] | (ROOT_W'(1) << b);
                end
                else
                begin
                    rem_next[s][l] = rem_in[s][l];
                    y2_next[s][l]  = y2_in[s][l];
                    y_next[s][l]   = y_in[s][l];
                end
            end
        end
    end

    always_comb
    begin
        logic [DW-1:0] step_v;
        root_ok = 1'b1;
        for (int l = 0; l < LANES; l++)
        begin
            f[l]   = sel_reg[STAGES-1][l] ? y_reg[STAGES-1][l]
                                          : F_W'(linf_reg[STAGES-1][l]);
            step_v = (DW'(y2_reg[STAGES-1][l]) << 1) + DW'(y2_reg[STAGES-1][l])
                     + (DW'(y_reg[STAGES-1][l]) << 1) + DW'(y_reg[STAGES-1][l]) + DW'(1);
            if (DW'(rem_reg[STAGES-1][l]) >= step_v)
            begin
                root_ok = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int s = 0; s < STAGES; s++)
            begin
                if (adv[s])
                begin
                    valid_reg[s] <= valid_in[s];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            p_reg <= p_next;
        end
        for (int s = 0; s < STAGES; s++)
        begin
            if (adv[s])
            begin
                y_reg[s]   <= y_next[s];
                y2_reg[s]  <= y2_next[s];
                rem_reg[s] <= rem_next[s];
                sel_reg[s] <= sel_in[s];
            end
        end
        for (int s = 1; s < STAGES; s++)
        begin
            if (adv[s])
            begin
                linf_reg[s] <= linf_in[s];
            end
        end
    end

    `S2LAB_ASSERT_IMPLY(a_root_is_largest, valid_reg[STAGES-1], root_ok)

endmodule

`default_nettype wire

// ===== src/s2lab_output.sv =====
`default_nettype none

module s2lab_output
    import s2lab_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  cie_f_t [LANES-1:0]     f,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [13:0]            lightness,
    output logic signed [14:0]     green_red,
    output logic signed [14:0]     blue_yellow
);

    localparam int STAGES = 2;
    localparam int LP_W   = 40;
    localparam int AP_W   = 43;

    localparam logic [LP_W-1:0]          L_SCALE   = 40'd11600;
    localparam logic signed [AP_W-1:0]   A_SCALE   = 43'sd50000;
    localparam logic signed [AP_W-1:0]   B_SCALE   = 43'sd20000;
    localparam logic [LP_W-1:0]          L_HALF    = 40'd524288;
    localparam logic signed [AP_W:0]     AB_HALF   = 44'sd524288;
    localparam logic signed [21:0]       L_OFFSET  = 22'sd1600;
    localparam logic signed [21:0]       L_MAX     = 22'sd10000;
    localparam logic signed [23:0]       AB_MIN    = -24'sd12800;
    localparam logic signed [23:0]       AB_MAX    = 24'sd12799;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_in;
    logic [STAGES:0]   adv;

    logic signed [F_W:0]    dx;
    logic signed [F_W:0]    dz;
    logic [LP_W-1:0]        lp_next;
    logic [LP_W-1:0]        lp_reg;
    logic signed [AP_W-1:0] ap_next;
    logic signed [AP_W-1:0] ap_reg;
    logic signed [AP_W-1:0] bp_next;
    logic signed [AP_W-1:0] bp_reg;
    logic [20:0]            l_round;
    logic signed [21:0]     l_shift;
    logic signed [23:0]     a_round;
    logic signed [23:0]     b_round;
    logic [13:0]            lightness_next;
    logic [13:0]            lightness_reg;
    logic signed [14:0]     green_red_next;
    logic signed [14:0]     green_red_reg;
    logic signed [14:0]     blue_yellow_next;
    logic signed [14:0]     blue_yellow_reg;

    function automatic logic signed [14:0] sat_ab(input logic signed [23:0] v);
        if (v < AB_MIN)
        begin
            return 15'(AB_MIN);
        end
        if (v > AB_MAX)
        begin
            return 15'(AB_MAX);
        end
        return 15'(v);
    endfunction

    always_comb
    begin
        adv[STAGES] = !out_stall;
        for (int s = STAGES - 1; s >= 0; s--)
        begin
            adv[s] = !valid_reg[s] || adv[s+1];
        end
    end

    assign valid_in    = {valid_reg[STAGES-2:0], in_valid};
    assign in_stall    = !adv[0];
    assign out_valid   = valid_reg[STAGES-1];
    assign lightness   = lightness_reg;
    assign green_red   = green_red_reg;
    assign blue_yellow = blue_yellow_reg;

    always_comb
    begin
        dx      = $signed({1'b0, f[0]}) - $signed({1'b0, f[1]});
        dz      = $signed({1'b0, f[1]}) - $signed({1'b0, f[2]});
        lp_next = LP_W'(f[1]) * L_SCALE;
        ap_next = AP_W'(dx) * A_SCALE;
        bp_next = AP_W'(dz) * B_SCALE;
    end

    // round half up in q20, then saturate
    always_comb
    begin
        l_round = 21'((lp_reg + L_HALF) >> 20);
        l_shift = $signed({1'b0, l_round}) - L_OFFSET;
        a_round = 24'(((AP_W + 1)'(ap_reg) + AB_HALF) >>> 20);
        b_round = 24'(((AP_W + 1)'(bp_reg) + AB_HALF) >>> 20);
        if (l_shift < 0)
        begin
            lightness_next = '0;
        end
        else if (l_shift > L_MAX)
        begin
            lightness_next = 14'(L_MAX);
        end
        else
        begin
            lightness_next = 14'(l_shift);
        end
        green_red_next   = sat_ab(a_round);
        blue_yellow_next = sat_ab(b_round);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int s = 0; s < STAGES; s++)
            begin
                if (adv[s])
                begin
                    valid_reg[s] <= valid_in[s];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            lp_reg <= lp_next;
            ap_reg <= ap_next;
            bp_reg <= bp_next;
        end
        if (adv[1])
        begin
            lightness_reg   <= lightness_next;
            green_red_reg   <= green_red_next;
            blue_yellow_reg <= blue_yellow_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/srgb_to_cielab_unit.sv =====
// sRGB to CIELAB converter. One 8-bit gamma-encoded pixel enters per clock and one
// L*, a*, b* result leaves per clock when nothing stalls. The pipeline runs through
// the transfer-curve lookup and the XYZ matrix, the pipelined divider by the white
// point (four quotient bits a stage), the cube root of f() (one root bit a stage)
// and the scaling, rounding and saturation. Every stage holds its own valid bit and
// moves as soon as the stage after it is free, so a stall at the output only backs
// up the stages that are full. L* is 0..10000 in hundredths, a* and b* are two's
// complement hundredths saturated to -12800..12799. The white point registers
// (thousandths, a zero value acts as one) reset to D65 and must only be written
// while no pixel is in flight.
`default_nettype none

`include "srgb_to_cielab_unit_assert.svh"

module srgb_to_cielab_unit
    import s2lab_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   pixel_valid,
    output logic                   pixel_stall,
    input  logic [7:0]             red,
    input  logic [7:0]             green,
    input  logic [7:0]             blue,
    output logic                   lab_valid,
    input  logic                   lab_stall,
    output logic [13:0]            lightness,
    output logic signed [14:0]     green_red,
    output logic signed [14:0]     blue_yellow,
    input  logic                   cfg_write,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [WHITE_W-1:0]     cfg_data
);

    white_t [LANES-1:0] white_reg;

    logic               mat_valid;
    logic               mat_stall;
    sum_t [LANES-1:0]   mat_sums;
    logic               div_valid;
    logic               div_stall;
    sum_t [LANES-1:0]   div_ratio;
    logic               root_valid;
    logic               root_stall;
    cie_f_t [LANES-1:0] root_f;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            white_reg[0] <= WHITE_X_RST;
            white_reg[1] <= WHITE_Y_RST;
            white_reg[2] <= WHITE_Z_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_WHITE_X: white_reg[0] <= cfg_data;
                REG_WHITE_Y: white_reg[1] <= cfg_data;
                REG_WHITE_Z: white_reg[2] <= cfg_data;
                default:     ;
            endcase
        end
    end

    s2lab_matrix u_matrix
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pixel_valid),
        .in_stall  (pixel_stall),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .out_valid (mat_valid),
        .out_stall (mat_stall),
        .sums      (mat_sums)
    );

    s2lab_ratio u_ratio
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mat_valid),
        .in_stall  (mat_stall),
        .sums      (mat_sums),
        .white     (white_reg),
        .out_valid (div_valid),
        .out_stall (div_stall),
        .ratio     (div_ratio)
    );

    s2lab_cbrt u_cbrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid),
        .in_stall  (div_stall),
        .ratio     (div_ratio),
        .out_valid (root_valid),
        .out_stall (root_stall),
        .f         (root_f)
    );

    s2lab_output u_output
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (root_valid),
        .in_stall    (root_stall),
        .f           (root_f),
        .out_valid   (lab_valid),
        .out_stall   (lab_stall),
        .lightness   (lightness),
        .green_red   (green_red),
        .blue_yellow (blue_yellow)
    );

    `S2LAB_ASSERT_IMPLY(a_empty_out_takes_pixel, !lab_valid, !pixel_stall)
    `S2LAB_ASSERT_IMPLY(a_draining_takes_pixel, !lab_stall, !pixel_stall)
    `S2LAB_ASSERT_ALWAYS(a_lightness_in_range, !lab_valid || (lightness <= 14'd10000))

endmodule

`default_nettype wire
